// File: rtl/gil_pkg.sv
// Shared types and constants for the glyph index lookup block.
package gil_pkg;

    localparam int TABLE_BYTES = 65536;
    localparam int ADDR_W      = $clog2(TABLE_BYTES);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic FMT_SEG4  = 1'b0;
    localparam logic FMT_GRP12 = 1'b1;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_GLIMIT = 2'd2;

    localparam logic [16:0] LEN_MAX        = 17'h10000;
    localparam logic [16:0] F4_MIN_LEN     = 17'd14;
    localparam logic [15:0] F4_SEGX2_POS   = 16'd6;
    localparam logic [15:0] F4_ENDS_POS    = 16'd14;
    localparam logic [15:0] F4_HDR_BYTES   = 16'd16;
    localparam logic [15:0] F12_COUNT_POS  = 16'd12;
    localparam logic [16:0] F12_HDR_BYTES  = 17'd16;
    localparam logic [15:0] F12_END_OFS    = 16'd4;
    localparam logic [15:0] F12_GLYPH_OFS  = 16'd8;

    typedef struct packed {
        logic        fmt;
        logic [16:0] len;
        logic [15:0] glim;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_PROBE,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_F4_SEGS,
        STEP_F4_END,
        STEP_F4_START,
        STEP_F4_OFFS,
        STEP_F4_GLYPH,
        STEP_F4_DELTA,
        STEP_F12_COUNT,
        STEP_F12_START,
        STEP_F12_END,
        STEP_F12_BASE
    } step_t;

endpackage

// File: rtl/glyph_index_lookup.sv
// Top level: configuration registers, table byte memory and lookup sequencer.
// A lookup reads the byte memory one byte per cycle, one field at a time; a format 4
// lookup scans the segment end codes in order and a format 12 lookup does a binary
// search over the groups.
// One request is in flight at a time; a finished result waits in the output register.
// Synchronous active-low reset clears control state and configuration registers; memory is not cleared.
module glyph_index_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [15:0] s_byte_address,
    input  logic [7:0]  s_byte_value,
    input  logic [20:0] s_codepoint,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_glyph,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    gil_pkg::cfg_t cfg_reg;
    logic          idle, wr_en, go;
    logic [gil_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign wr_en     = s_valid && idle && (s_op == gil_pkg::OP_WRITE);
    assign go        = s_valid && idle && (s_op == gil_pkg::OP_LOOKUP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gil_pkg::REG_FORMAT: cfg_reg.fmt  <= cfg_data[0];
                gil_pkg::REG_LENGTH: cfg_reg.len  <= cfg_data;
                gil_pkg::REG_GLIMIT: cfg_reg.glim <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    gil_ram #(
        .WIDTH(8),
        .DEPTH(gil_pkg::TABLE_BYTES)
    ) u_ram (
        .clk  (aclk),
        .we   (wr_en),
        .addr (wr_en ? s_byte_address : rd_addr),
        .wdata(s_byte_value),
        .rdata(rd_data)
    );

    gil_seq u_seq (
        .clk      (aclk),
        .rstn     (aresetn),
        .cfg      (cfg_reg),
        .go       (go),
        .cp_in    (s_codepoint),
        .idle     (idle),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res_valid(m_valid),
        .res_glyph(m_glyph),
        .res_ready(m_ready)
    );

endmodule

// File: rtl/gil_ram.sv
// Generic single-port synchronous RAM with registered read data.
module gil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/gil_seq.sv
// Lookup sequencer: walks the subtable in memory and holds the result register.
module gil_seq (
    input  logic                       clk,
    input  logic                       rstn,
    input  gil_pkg::cfg_t              cfg,
    input  logic                       go,
    input  logic [20:0]                cp_in,
    output logic                       idle,
    output logic [gil_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       res_valid,
    output logic [15:0]                res_glyph,
    input  logic                       res_ready
);

    gil_pkg::state_t state_reg, state_next;
    gil_pkg::step_t  step_reg, step_next;
    logic [20:0] cp_reg, cp_next;
    logic [16:0] len_reg, len_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] faddr_reg, faddr_next;
    logic [2:0]  fn_reg, fn_next, iss_reg, iss_next, rcv_reg, rcv_next;
    logic        pend_reg, pend_next;
    logic [14:0] segs_reg, segs_next, i_reg, i_next;
    logic [15:0] seg2_reg, seg2_next, off_reg, off_next, val_reg, val_next;
    logic [31:0] start_reg, start_next;
    logic [12:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [15:0] grp_reg, grp_next, res_reg, res_next, glyph_reg, glyph_next;
    logic        mval_reg, mval_next;

    logic [16:0] seg3_w, ranges_w, cnt12_w, grp_w;
    logic [18:0] need_w, pos_w;
    logic [13:0] sum_w;
    logic [12:0] mid_w;
    logic [31:0] g12_w;
    logic [15:0] g4_w;

    assign idle      = (state_reg == gil_pkg::S_IDLE);
    assign res_valid = mval_reg;
    assign res_glyph = glyph_reg;
    assign rd_addr   = faddr_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= gil_pkg::S_IDLE;
            pend_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            mval_reg  <= mval_next;
        end
        step_reg  <= step_next;
        cp_reg    <= cp_next;
        len_reg   <= len_next;
        acc_reg   <= acc_next;
        faddr_reg <= faddr_next;
        fn_reg    <= fn_next;
        iss_reg   <= iss_next;
        rcv_reg   <= rcv_next;
        segs_reg  <= segs_next;
        i_reg     <= i_next;
        seg2_reg  <= seg2_next;
        off_reg   <= off_next;
        val_reg   <= val_next;
        start_reg <= start_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        grp_reg   <= grp_next;
        res_reg   <= res_next;
        glyph_reg <= glyph_next;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cp_next    = cp_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        faddr_next = faddr_reg;
        fn_next    = fn_reg;
        iss_next   = iss_reg;
        rcv_next   = rcv_reg;
        pend_next  = 1'b0;
        segs_next  = segs_reg;
        i_next     = i_reg;
        seg2_next  = seg2_reg;
        off_next   = off_reg;
        val_next   = val_reg;
        start_next = start_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        grp_next   = grp_reg;
        res_next   = res_reg;
        glyph_next = glyph_reg;
        mval_next  = mval_reg;

        seg3_w   = {1'b0, seg2_reg} + {1'b0, seg2_reg} + {1'b0, seg2_reg};
        ranges_w = {1'b0, gil_pkg::F4_HDR_BYTES} + seg3_w + {1'b0, off_reg};
        need_w   = {1'b0, acc_reg[15:1], 3'b000} + {3'b000, gil_pkg::F4_HDR_BYTES};
        pos_w    = {2'b00, ranges_w} + {3'b000, acc_reg[15:0]}
                 + {2'b00, (cp_reg[15:0] - start_reg[15:0]), 1'b0};
        cnt12_w  = {1'b0, acc_reg[12:0], 3'b000} + {2'b00, acc_reg[12:0], 2'b00};
        sum_w    = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid_w    = sum_w[13:1];
        grp_w    = {1'b0, mid_w, 3'b000} + {2'b00, mid_w, 2'b00} + gil_pkg::F12_HDR_BYTES;
        g12_w    = acc_reg + ({11'd0, cp_reg} - start_reg);
        g4_w     = val_reg + acc_reg[15:0];

        if (mval_reg && res_ready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            gil_pkg::S_IDLE: begin
                if (go) begin
                    cp_next  = cp_in;
                    len_next = (cfg.len > gil_pkg::LEN_MAX) ? gil_pkg::LEN_MAX : cfg.len;
                    acc_next = '0;
                    iss_next = '0;
                    rcv_next = '0;
                    res_next = '0;
                    if (cfg.len == '0) begin
                        state_next = gil_pkg::S_OUT;
                    end else if (cfg.fmt == gil_pkg::FMT_GRP12) begin
                        if (cfg.len < gil_pkg::F12_HDR_BYTES) begin
                            state_next = gil_pkg::S_OUT;
                        end else begin
                            faddr_next = gil_pkg::F12_COUNT_POS;
                            fn_next    = 3'd4;
                            step_next  = gil_pkg::STEP_F12_COUNT;
                            state_next = gil_pkg::S_FETCH;
                        end
                    end else begin
                        if (cp_in > 21'h00ffff || cfg.len < gil_pkg::F4_MIN_LEN) begin
                            state_next = gil_pkg::S_OUT;
                        end else begin
                            faddr_next = gil_pkg::F4_SEGX2_POS;
                            fn_next    = 3'd2;
                            step_next  = gil_pkg::STEP_F4_SEGS;
                            state_next = gil_pkg::S_FETCH;
                        end
                    end
                end
            end
            gil_pkg::S_FETCH: begin
                if (iss_reg < fn_reg) begin
                    faddr_next = faddr_reg + 16'd1;
                    iss_next   = iss_reg + 3'd1;
                    pend_next  = 1'b1;
                end
                if (pend_reg) begin
                    acc_next = {acc_reg[23:0], rd_data};
                    rcv_next = rcv_reg + 3'd1;
                    if (rcv_reg + 3'd1 == fn_reg) begin
                        state_next = gil_pkg::S_EVAL;
                    end
                end
            end
            gil_pkg::S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_w;
                    grp_next   = grp_w[15:0];
                    faddr_next = grp_w[15:0];
                    fn_next    = 3'd4;
                    iss_next   = '0;
                    rcv_next   = '0;
                    step_next  = gil_pkg::STEP_F12_START;
                    state_next = gil_pkg::S_FETCH;
                end else begin
                    res_next   = '0;
                    state_next = gil_pkg::S_OUT;
                end
            end
            gil_pkg::S_EVAL: begin
                iss_next   = '0;
                rcv_next   = '0;
                state_next = gil_pkg::S_FETCH;
                case (step_reg)
                    gil_pkg::STEP_F4_SEGS: begin
                        segs_next  = acc_reg[15:1];
                        seg2_next  = {acc_reg[15:1], 1'b0};
                        i_next     = '0;
                        off_next   = '0;
                        faddr_next = gil_pkg::F4_ENDS_POS;
                        fn_next    = 3'd2;
                        step_next  = gil_pkg::STEP_F4_END;
                        if (acc_reg[15:1] == '0 || need_w > {2'b00, len_reg}) begin
                            state_next = gil_pkg::S_OUT;
                        end
                    end
                    gil_pkg::STEP_F4_END: begin
                        fn_next = 3'd2;
                        if (acc_reg[15:0] < cp_reg[15:0]) begin
                            i_next     = i_reg + 15'd1;
                            off_next   = off_reg + 16'd2;
                            faddr_next = gil_pkg::F4_ENDS_POS + off_reg + 16'd2;
                            if (i_reg + 15'd1 == segs_reg) begin
                                state_next = gil_pkg::S_OUT;
                            end
                        end else begin
                            faddr_next = gil_pkg::F4_HDR_BYTES + seg2_reg + off_reg;
                            step_next  = gil_pkg::STEP_F4_START;
                        end
                    end
                    gil_pkg::STEP_F4_START: begin
                        start_next = acc_reg;
                        fn_next    = 3'd2;
                        faddr_next = ranges_w[15:0];
                        step_next  = gil_pkg::STEP_F4_OFFS;
                        if (acc_reg[15:0] > cp_reg[15:0]) begin
                            state_next = gil_pkg::S_OUT;
                        end
                    end
                    gil_pkg::STEP_F4_OFFS: begin
                        fn_next = 3'd2;
                        if (acc_reg[15:0] == '0) begin
                            val_next   = cp_reg[15:0];
                            faddr_next = gil_pkg::F4_HDR_BYTES + seg2_reg + seg2_reg + off_reg;
                            step_next  = gil_pkg::STEP_F4_DELTA;
                        end else begin
                            faddr_next = pos_w[15:0];
                            step_next  = gil_pkg::STEP_F4_GLYPH;
                            if (pos_w + 19'd2 > {2'b00, len_reg}) begin
                                state_next = gil_pkg::S_OUT;
                            end
                        end
                    end
                    gil_pkg::STEP_F4_GLYPH: begin
                        val_next   = acc_reg[15:0];
                        fn_next    = 3'd2;
                        faddr_next = gil_pkg::F4_HDR_BYTES + seg2_reg + seg2_reg + off_reg;
                        step_next  = gil_pkg::STEP_F4_DELTA;
                        if (acc_reg[15:0] == '0) begin
                            state_next = gil_pkg::S_OUT;
                        end
                    end
                    gil_pkg::STEP_F4_DELTA: begin
                        res_next   = (g4_w < cfg.glim) ? g4_w : '0;
                        state_next = gil_pkg::S_OUT;
                    end
                    gil_pkg::STEP_F12_COUNT: begin
                        lo_next    = '0;
                        hi_next    = acc_reg[12:0];
                        state_next = gil_pkg::S_PROBE;
                        if (acc_reg[31:13] != '0 || cnt12_w > len_reg - gil_pkg::F12_HDR_BYTES) begin
                            state_next = gil_pkg::S_OUT;
                        end
                    end
                    gil_pkg::STEP_F12_START: begin
                        start_next = acc_reg;
                        fn_next    = 3'd4;
                        faddr_next = grp_reg + gil_pkg::F12_END_OFS;
                        step_next  = gil_pkg::STEP_F12_END;
                    end
                    gil_pkg::STEP_F12_END: begin
                        fn_next = 3'd4;
                        if ({11'd0, cp_reg} > acc_reg) begin
                            lo_next    = mid_reg + 13'd1;
                            state_next = gil_pkg::S_PROBE;
                        end else if ({11'd0, cp_reg} < start_reg) begin
                            hi_next    = mid_reg;
                            state_next = gil_pkg::S_PROBE;
                        end else begin
                            faddr_next = grp_reg + gil_pkg::F12_GLYPH_OFS;
                            step_next  = gil_pkg::STEP_F12_BASE;
                        end
                    end
                    gil_pkg::STEP_F12_BASE: begin
                        res_next   = (g12_w < {16'd0, cfg.glim}) ? g12_w[15:0] : '0;
                        state_next = gil_pkg::S_OUT;
                    end
                    default: begin
                        state_next = gil_pkg::S_OUT;
                    end
                endcase
            end
            gil_pkg::S_OUT: begin
                if (!mval_reg || res_ready) begin
                    mval_next  = 1'b1;
                    glyph_next = res_reg;
                    state_next = gil_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gil_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/gil_checker.sv
// Port-level checker for the glyph index lookup block, with its bind.
module gil_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_op,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_glyph
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_glyph))
        else $error("Result changed while stalled.");

    a_busy_after_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == gil_pkg::OP_LOOKUP |=> !s_ready)
        else $error("Request accepted while a lookup was in progress.");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("Result appeared without a lookup in progress.");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind glyph_index_lookup gil_checker u_gil_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_op   (s_op),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_glyph(m_glyph)
);
